// ===== src/mpd_pkg.sv =====
// Shared types and constants of the mouse packet decoder.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package mpd_pkg;

    // Values of the event kind field.
    localparam logic [1:0] KIND_BUTTON = 2'd0;
    localparam logic [1:0] KIND_MOTION = 2'd1;
    localparam logic [1:0] KIND_SYNC   = 2'd2;

    // Values of the event code field.
    localparam logic [1:0] CODE_LEFT   = 2'd0;
    localparam logic [1:0] CODE_RIGHT  = 2'd1;
    localparam logic [1:0] CODE_MIDDLE = 2'd2;
    localparam logic [1:0] CODE_X      = 2'd0;
    localparam logic [1:0] CODE_Y      = 2'd1;
    localparam logic [1:0] CODE_WHEEL  = 2'd2;
    localparam logic [1:0] CODE_SYNC   = 2'd0;

    // Slots of the pending-event mask, in the order the events leave.
    localparam int unsigned NUM_EVENTS = 7;
    localparam logic [2:0] EV_LEFT   = 3'd0;
    localparam logic [2:0] EV_RIGHT  = 3'd1;
    localparam logic [2:0] EV_MIDDLE = 3'd2;
    localparam logic [2:0] EV_X      = 3'd3;
    localparam logic [2:0] EV_Y      = 3'd4;
    localparam logic [2:0] EV_WHEEL  = 3'd5;
    localparam logic [2:0] EV_SYNC   = 3'd6;

    // Status byte bits.
    localparam int unsigned SYNC_BIT  = 3;
    localparam logic [7:0]  OVF_MASK  = 8'hC0;

    // Register map.
    localparam logic REG_WHEEL_ENABLED = 1'b0;

    // A complete packet as handed from the front end to the event sequencer.
    typedef struct packed {
        logic [7:0] status;
        logic [7:0] dx;
        logic [7:0] dy;
        logic [7:0] dw;
        logic       wheel;
    } pkt_t;

endpackage

`default_nettype wire

// ===== src/mpd_front.sv =====
// Front end: collects received bytes into packets and resynchronizes on the status byte.
// Depends on mpd_pkg.
`default_nettype none

module mpd_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wheel_enabled,
    input  wire logic          in_valid,
    input  wire logic [7:0]    in_byte,
    input  wire logic          q_full,
    output logic               in_ready,
    output logic               push,
    output mpd_pkg::pkt_t      pkt
);

    logic [1:0] byte_index_reg;
    logic [1:0] byte_index_next;
    logic [7:0] bytes_reg [0:2];
    logic       accept;
    logic       drop;
    logic       complete;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign drop     = (byte_index_reg == 2'd0) && !in_byte[mpd_pkg::SYNC_BIT];
    // The packet ends on the fourth byte, or on the third one outside wheel mode.
    assign complete = (byte_index_reg == 2'd3) ||
                      ((byte_index_reg == 2'd2) && !wheel_enabled);
    assign push     = accept && !drop && complete;

    always_comb
    begin
        pkt.status = bytes_reg[0];
        pkt.dx     = bytes_reg[1];
        pkt.dy     = (byte_index_reg == 2'd2) ? in_byte : bytes_reg[2];
        pkt.dw     = in_byte;
        pkt.wheel  = wheel_enabled;
    end

    always_comb
    begin
        byte_index_next = byte_index_reg;
        if (accept && !drop)
        begin
            if (complete)
                byte_index_next = 2'd0;
            else
                byte_index_next = byte_index_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_index_reg <= 2'd0;
        else
            byte_index_reg <= byte_index_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && !drop && !complete)
            bytes_reg[byte_index_reg] <= in_byte;
    end

endmodule

`default_nettype wire

// ===== src/mpd_queue.sv =====
// Two-entry queue of complete packets between the front end and the sequencer.
// Depends on mpd_pkg.
`default_nettype none

module mpd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire mpd_pkg::pkt_t push_pkt,
    input  wire logic          pop,
    output logic               full,
    output logic               empty,
    output mpd_pkg::pkt_t      head
);

    mpd_pkg::pkt_t mem_reg [0:1];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_pkt;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("packet pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("packet popped from an empty queue");

endmodule

`default_nettype wire

// ===== src/mpd_back.sv =====
// Event sequencer: turns one packet into its button, motion and sync events.
// Depends on mpd_pkg; holds the output register of the result stream.
`default_nettype none

module mpd_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  wire mpd_pkg::pkt_t q_head,
    output logic               pop,
    input  wire logic          out_ready,
    output logic               out_valid,
    output logic [1:0]         out_kind,
    output logic [1:0]         out_code,
    output logic [8:0]         out_value,
    output logic               out_last
);

    localparam int unsigned NE = mpd_pkg::NUM_EVENTS;

    mpd_pkg::pkt_t pkt_reg;
    logic [NE-1:0] mask_reg;
    logic [NE-1:0] mask_next;
    logic [NE-1:0] load_mask;
    logic [2:0]    sel;
    logic          issue;
    logic          ovf;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [1:0]    kind_reg;
    logic [1:0]    code_reg;
    logic [8:0]    value_reg;
    logic          last_reg;
    logic [1:0]    kind_next;
    logic [1:0]    code_next;
    logic [8:0]    value_next;
    logic          last_next;

    assign pop   = (mask_reg == '0) && !q_empty;
    assign issue = (mask_reg != '0) && (!out_valid_reg || out_ready);
    assign ovf   = (q_head.status & mpd_pkg::OVF_MASK) != 8'h00;

    // Which events a freshly loaded packet produces.
    always_comb
    begin
        load_mask                    = '0;
        load_mask[mpd_pkg::EV_LEFT]   = 1'b1;
        load_mask[mpd_pkg::EV_RIGHT]  = 1'b1;
        load_mask[mpd_pkg::EV_MIDDLE] = 1'b1;
        load_mask[mpd_pkg::EV_X]      = !ovf && (q_head.dx != 8'h00);
        load_mask[mpd_pkg::EV_Y]      = !ovf && (q_head.dy != 8'h00);
        load_mask[mpd_pkg::EV_WHEEL]  = !ovf && q_head.wheel && (q_head.dw != 8'h00);
        load_mask[mpd_pkg::EV_SYNC]   = 1'b1;
    end

    // Lowest pending event goes out first.
    always_comb
    begin
        sel = mpd_pkg::EV_SYNC;
        for (int i = NE - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
                sel = 3'(i);
        end
    end

    always_comb
    begin
        kind_next  = mpd_pkg::KIND_SYNC;
        code_next  = mpd_pkg::CODE_SYNC;
        value_next = 9'd0;
        last_next  = 1'b0;
        case (sel)
            mpd_pkg::EV_LEFT:
            begin
                kind_next  = mpd_pkg::KIND_BUTTON;
                code_next  = mpd_pkg::CODE_LEFT;
                value_next = {8'd0, pkt_reg.status[0]};
            end
            mpd_pkg::EV_RIGHT:
            begin
                kind_next  = mpd_pkg::KIND_BUTTON;
                code_next  = mpd_pkg::CODE_RIGHT;
                value_next = {8'd0, pkt_reg.status[1]};
            end
            mpd_pkg::EV_MIDDLE:
            begin
                kind_next  = mpd_pkg::KIND_BUTTON;
                code_next  = mpd_pkg::CODE_MIDDLE;
                value_next = {8'd0, pkt_reg.status[2]};
            end
            mpd_pkg::EV_X:
            begin
                kind_next  = mpd_pkg::KIND_MOTION;
                code_next  = mpd_pkg::CODE_X;
                value_next = {pkt_reg.dx[7], pkt_reg.dx};
            end
            mpd_pkg::EV_Y:
            begin
                // Y grows upward on the wire; a byte of -128 becomes +128.
                kind_next  = mpd_pkg::KIND_MOTION;
                code_next  = mpd_pkg::CODE_Y;
                value_next = 9'd0 - {pkt_reg.dy[7], pkt_reg.dy};
            end
            mpd_pkg::EV_WHEEL:
            begin
                kind_next  = mpd_pkg::KIND_MOTION;
                code_next  = mpd_pkg::CODE_WHEEL;
                value_next = {pkt_reg.dw[7], pkt_reg.dw};
            end
            default:
            begin
                kind_next  = mpd_pkg::KIND_SYNC;
                code_next  = mpd_pkg::CODE_SYNC;
                value_next = 9'd0;
                last_next  = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        mask_next = mask_reg;
        if (pop)
            mask_next = load_mask;
        else if (issue)
            mask_next = mask_reg & ~(NE'(1) << sel);

        out_valid_next = out_valid_reg;
        if (issue)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            pkt_reg <= q_head;
        if (issue)
        begin
            kind_reg  <= kind_next;
            code_reg  <= code_next;
            value_reg <= value_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = kind_reg;
    assign out_code  = code_reg;
    assign out_value = value_reg;
    assign out_last  = last_reg;

    a_sync_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (mask_reg != '0) |-> mask_reg[mpd_pkg::EV_SYNC])
        else $error("packet in progress has lost its closing sync event");

    a_last_is_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> (kind_reg == mpd_pkg::KIND_SYNC))
        else $error("last flag raised on an event that is not a sync");

endmodule

`default_nettype wire

// ===== src/mouse_packet_decoder_top.sv =====
// Mouse packet decoder: received bytes in, button/motion/sync events out.
// A completing byte enters the two-entry queue, the sequencer loads its packet, and
// the first event enters the output register. Throughput: one byte per cycle while
// the queue has room; after each load, one event per cycle unless the output stalls.
// Reset (rst_n, asynchronous, active low) clears the byte index, the queue, the
// sequencer, the output valid flag and wheel_enabled; no memory clearing pass.
// Depends on mpd_pkg, mpd_front, mpd_queue and mpd_back.
`default_nettype none

module mouse_packet_decoder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Received byte stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // [7:0] rx_byte

    // Event stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,     // [8:0] event_value, [15:9] zero
    output logic [3:0]       m_tuser,     // [1:0] event_kind, [3:2] event_code
    output logic             m_tlast,     // last_event

    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // The only register, wheel_enabled, sits at byte address 0. Writes are taken
    // in the access phase; the word index is bit 2 of the address.
    logic wheel_enabled_reg;
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wheel_enabled_reg <= 1'b0;
        else if (cfg_write && (paddr[2] == mpd_pkg::REG_WHEEL_ENABLED))
            wheel_enabled_reg <= pwdata[0];
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == mpd_pkg::REG_WHEEL_ENABLED)
            prdata = {31'd0, wheel_enabled_reg};
    end

    // Front end assembles packets; each complete packet enters the queue, and
    // the sequencer drains it one event per cycle, unless stalled, into the output register.
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;
    mpd_pkg::pkt_t front_pkt;
    mpd_pkg::pkt_t q_head;
    logic [1:0]    out_kind;
    logic [1:0]    out_code;
    logic [8:0]    out_value;

    mpd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .wheel_enabled (wheel_enabled_reg),
        .in_valid      (s_tvalid),
        .in_byte       (s_tdata),
        .q_full        (q_full),
        .in_ready      (s_tready),
        .push          (push),
        .pkt           (front_pkt)
    );

    mpd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_pkt (front_pkt),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    mpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .pop       (pop),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_kind  (out_kind),
        .out_code  (out_code),
        .out_value (out_value),
        .out_last  (m_tlast)
    );

    assign m_tdata = {7'd0, out_value};
    assign m_tuser = {out_code, out_kind};

endmodule

`default_nettype wire
